FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// switched off while reset is held
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/chb_pkg.sv
// ----------------------------------------------------------------------------
// chb_pkg
// types, constants and helpers shared by the histogram binner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chb_pkg;

  // counter store
  localparam int unsigned NUM_BINS = 32;
  localparam int unsigned IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SAMPLE_W  = 20;
  localparam int unsigned BIN_W     = 5;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned TOP_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // restoring divider, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = SAMPLE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // small queues
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ_CLEAR = 2'd2;

  // register reset values
  localparam logic [SAMPLE_W-1:0] LOWER_RST = '0;
  localparam logic [SAMPLE_W-1:0] UPPER_RST = '1;
  localparam logic [SAMPLE_W-1:0] WIDTH_RST = SAMPLE_W'(1);
  localparam logic [TOP_W-1:0]    TOP_RST   = '1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER,
    CFG_UPPER,
    CFG_WIDTH,
    CFG_TOP
  } cfg_reg_e;

  // work handed from front to back
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_CLEAR,
    OP_VOID
  } op_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_CLAMP,
    FE_SEND
  } fe_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]    bin_select;
  } chb_in_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_number;
    logic [COUNT_W-1:0] bin_count;
  } chb_out_t;

  typedef struct packed {
    op_e              op;
    logic [BIN_W-1:0] bin;
  } chb_cmd_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lower;
    logic [SAMPLE_W-1:0] upper;
    logic [SAMPLE_W-1:0] width;
    logic [TOP_W-1:0]    top;
  } chb_cfg_t;

  // last usable bin, limited by the store depth
  function automatic logic [BIN_W-1:0] eff_top(input logic [TOP_W-1:0] top);
    logic [BIN_W-1:0] res;
    if (32'(top) > NUM_BINS - 1) begin
      res = BIN_W'(NUM_BINS - 1);
    end else begin
      res = BIN_W'(top);
    end
    return res;
  endfunction

  function automatic logic bin_in_store(input logic [BIN_W-1:0] bin);
    return 32'(bin) < NUM_BINS;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/chb_front.sv
// ----------------------------------------------------------------------------
// chb_front
// takes one request, classifies it and works out the target bin
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  chb_pkg::chb_in_t   in_item_i,
  input  chb_pkg::chb_cfg_t  cfg_i,
  output logic               q_push_o,
  output chb_pkg::chb_cmd_t  q_item_o,
  input  logic               q_full_i
);
  import chb_pkg::*;

  fe_state_e              state_d, state_q;
  op_e                    op_d, op_q;
  logic [BIN_W-1:0]       bin_d, bin_q;
  logic [SAMPLE_W-1:0]    rem_d, rem_q;
  logic [SAMPLE_W-1:0]    quo_d, quo_q;
  logic [DIV_CNT_W-1:0]   cnt_d, cnt_q;

  logic                   accept;
  logic                   in_band;
  logic [SAMPLE_W-1:0]    width_eff;
  logic [SAMPLE_W:0]      rem_sh;
  logic [SAMPLE_W:0]      rem_sub;
  logic                   sub_ok;
  logic [BIN_W-1:0]       top;

  assign accept    = push_i && !full_o;
  assign in_band   = (in_item_i.sample >= cfg_i.lower) && (in_item_i.sample < cfg_i.upper);
  assign width_eff = (cfg_i.width == '0) ? SAMPLE_W'(1) : cfg_i.width;
  assign rem_sh    = {rem_q, quo_q[SAMPLE_W-1]};
  assign rem_sub   = rem_sh - {1'b0, width_eff};
  assign sub_ok    = rem_sh >= {1'b0, width_eff};
  assign top       = eff_top(cfg_i.top);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: begin
        if (accept) begin
          state_d = ((in_item_i.cmd == CMD_ADD) && in_band) ? FE_DIV : FE_SEND;
        end
      end
      FE_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = FE_CLAMP;
        end
      end
      FE_CLAMP: state_d = FE_SEND;
      FE_SEND: begin
        if (!q_full_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full_o   = 1'b1;
    q_push_o = 1'b0;
    unique case (state_q)
      FE_IDLE:  full_o = 1'b0;
      FE_SEND:  q_push_o = !q_full_i;
      default: begin
        full_o   = 1'b1;
        q_push_o = 1'b0;
      end
    endcase
  end

  assign q_item_o = '{op: op_q, bin: bin_q};

  // datapath
  always_comb begin
    op_d  = op_q;
    bin_d = bin_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    unique case (state_q)
      FE_IDLE: begin
        if (accept) begin
          priority if (in_item_i.cmd == CMD_ADD) begin
            op_d = OP_ADD;
            priority if (in_item_i.sample < cfg_i.lower) begin
              bin_d = '0;
            end else if (in_item_i.sample >= cfg_i.upper) begin
              bin_d = top;
            end else begin
              quo_d = in_item_i.sample - cfg_i.lower;
              rem_d = '0;
              cnt_d = '0;
            end
          end else if (!bin_in_store(in_item_i.bin_select)) begin
            op_d  = OP_VOID;
            bin_d = in_item_i.bin_select;
          end else begin
            // the spare code reads like a plain read
            op_d  = (in_item_i.cmd == CMD_READ_CLEAR) ? OP_CLEAR : OP_READ;
            bin_d = in_item_i.bin_select;
          end
        end
      end
      FE_DIV: begin
        rem_d = sub_ok ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
        quo_d = {quo_q[SAMPLE_W-2:0], sub_ok};
        cnt_d = cnt_q + DIV_CNT_W'(1);
      end
      FE_CLAMP: begin
        // quotient plus one, held at the top bin
        bin_d = (quo_q >= SAMPLE_W'(top)) ? top : BIN_W'(quo_q) + BIN_W'(1);
      end
      default: begin
        bin_d = bin_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    bin_q <= bin_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

endmodule

`default_nettype wire

FILE: hdl/chb_cmd_queue.sv
// ----------------------------------------------------------------------------
// chb_cmd_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chb_cmd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  chb_pkg::chb_cmd_t  item_i,
  output logic               full_o,
  input  logic               pop_i,
  output chb_pkg::chb_cmd_t  item_o,
  output logic               empty_o
);
  import chb_pkg::*;

  chb_cmd_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_d, wr_ptr_q;
  logic [Q_PTR_W-1:0]    rd_ptr_d, rd_ptr_q;
  logic [Q_CNT_W-1:0]    cnt_d, cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + Q_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - Q_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/chb_back.sv
// ----------------------------------------------------------------------------
// chb_back
// counter store, read-modify-write per request, result queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  chb_pkg::chb_cmd_t  cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_pop_i,
  output logic               res_empty_o,
  output chb_pkg::chb_out_t  res_item_o
);
  import chb_pkg::*;

  logic [COUNT_W-1:0]    counters_q [NUM_BINS];
  chb_out_t              res_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_d, wr_ptr_q;
  logic [Q_PTR_W-1:0]    rd_ptr_d, rd_ptr_q;
  logic [Q_CNT_W-1:0]    cnt_d, cnt_q;

  logic                  fire, do_pop;
  logic [IDX_W-1:0]      idx;
  logic [COUNT_W-1:0]    cur;
  logic                  wr_en;
  logic [COUNT_W-1:0]    wr_data;
  chb_out_t              res;

  assign fire        = cmd_valid_i && (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign cmd_pop_o   = fire;
  assign res_empty_o = cnt_q == '0;
  assign do_pop      = res_pop_i && !res_empty_o;
  assign res_item_o  = res_mem_q[rd_ptr_q];
  assign idx         = IDX_W'(cmd_i.bin);
  assign cur         = counters_q[idx];

  always_comb begin
    wr_en          = 1'b0;
    wr_data        = cur;
    res.bin_number = cmd_i.bin;
    res.bin_count  = cur;
    unique case (cmd_i.op)
      OP_ADD: begin
        // saturating increment
        wr_en         = fire;
        wr_data       = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
        res.bin_count = wr_data;
      end
      OP_CLEAR: begin
        wr_en   = fire;
        wr_data = '0;
      end
      OP_VOID:  res.bin_count = '0;
      default:  res.bin_count = cur;
    endcase
  end

  always_comb begin
    wr_ptr_d = fire   ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    unique case ({fire, do_pop})
      2'b10:   cnt_d = cnt_q + Q_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - Q_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        counters_q[i] <= '0;
      end
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        counters_q[idx] <= wr_data;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_mem_q[wr_ptr_q] <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clamped_histogram_binner_top.sv
// ----------------------------------------------------------------------------
// clamped_histogram_binner_top
// fixed-width histogram with clamped end bins and read / read-clear requests
// ----------------------------------------------------------------------------
// path: an add inside the bounds passes the 20 divider steps, the clamp, the
//   hand-over and the counter update; other requests skip divider and clamp
// flow: the front takes a new request only once the last one is handed on; an
//   in-band add also waits for the front's one-bit-per-cycle restoring divider
// reset: asynchronous, active low; clears counters, queues, config, front state
`timescale 1ns / 1ps
`default_nettype none

module clamped_histogram_binner_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request side
  input  logic                              push,
  output logic                              full,
  input  chb_pkg::chb_in_t                  in_item_i,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output chb_pkg::chb_out_t                 out_item_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [chb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [chb_pkg::SAMPLE_W-1:0]      cfg_data_i
);
  import chb_pkg::*;

  chb_cfg_t  cfg_d, cfg_q;

  // front to queue
  logic      fq_push;
  chb_cmd_t  fq_item;
  logic      fq_full;

  // queue to back
  logic      qb_empty;
  logic      qb_pop;
  chb_cmd_t  qb_item;

  // register file: writes are always taken; the user must write only while the block is idle (not enforced)
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LOWER: cfg_d.lower = cfg_data_i;
        CFG_UPPER: cfg_d.upper = cfg_data_i;
        CFG_WIDTH: cfg_d.width = cfg_data_i;
        CFG_TOP:   cfg_d.top   = cfg_data_i[TOP_W-1:0];
        default:   cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{lower: LOWER_RST, upper: UPPER_RST, width: WIDTH_RST, top: TOP_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: bounds tests and divider produce a bin per request
  chb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .q_push_o  (fq_push),
    .q_item_o  (fq_item),
    .q_full_i  (fq_full)
  );

  // short queue so front and back stall independently
  chb_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (fq_full),
    .pop_i   (qb_pop),
    .item_o  (qb_item),
    .empty_o (qb_empty)
  );

  // back: one counter update per cycle into the result queue, while that queue has room
  chb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!qb_empty),
    .cmd_i       (qb_item),
    .cmd_pop_o   (qb_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: hdl/chb_checker.sv
// ----------------------------------------------------------------------------
// chb_checker
// port-level assertions for the histogram binner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module chb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  chb_pkg::chb_out_t  out_item_i
);
  import chb_pkg::*;

  logic res_void;

  // a waiting result for a bin the store does not hold
  assign res_void = !empty_i && !bin_in_store(out_item_i.bin_number);

  // the front works on one request at a time
  `ASSERT_NXT(a_accept_blocks, clk_i, rst_ni, push_i && !full_i, full_i)

  // full only rises after an accepted request
  `ASSERT_IMP(a_full_needs_push, clk_i, rst_ni, $rose(full_i), $past(push_i))

  // a waiting result holds until taken
  `ASSERT_NXT(a_result_holds, clk_i, rst_ni, !empty_i && !pop_i, !empty_i && $stable(out_item_i))

  // a bin outside the store always reports zero
  `ASSERT_IMP(a_void_zero, clk_i, rst_ni, res_void, out_item_i.bin_count == '0)

endmodule

bind clamped_histogram_binner_top chb_checker u_chb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push_i     (push),
  .full_i     (full),
  .empty_i    (empty),
  .pop_i      (pop),
  .out_item_i (out_item_o)
);

`default_nettype wire

FILE: sim/tb_clamped_histogram_binner_top.sv
// ----------------------------------------------------------------------------
// tb_clamped_histogram_binner_top
// self-checking bench for the clamped histogram binner
// ----------------------------------------------------------------------------
// a short table of directed requests and register writes runs first, then
// about 1900 random requests over twelve register settings and three idling
// patterns; the table gives some results, an in-bench model of the bins
// predicts the rest, and results are checked in order as they leave the block
`timescale 1ns / 1ps

module tb_clamped_histogram_binner_top;
  import chb_pkg::*;

  // command codes the package does not name
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALIAS = 2'd3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned SUB_PHASES    = 4;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned TAIL_CYCLES   = 30;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  // one line of the directed table; value is the sample or the register data
  typedef struct {
    row_kind_e           kind;
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] value;
    logic [BIN_W-1:0]    sel;
    cfg_reg_e            reg_idx;
    bit                  typed;
    logic [BIN_W-1:0]    exp_bin;
    logic [COUNT_W-1:0]  exp_count;
  } stim_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  chb_in_t               in_item_i   = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  chb_out_t              out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [SAMPLE_W-1:0]   cfg_data_i  = '0;

  // bench copy of the registers and the counter store
  logic [SAMPLE_W-1:0]   hist_lower;
  logic [SAMPLE_W-1:0]   hist_upper;
  logic [SAMPLE_W-1:0]   hist_width;
  logic [TOP_W-1:0]      hist_top;
  logic [COUNT_W-1:0]    bin_tally [NUM_BINS];

  chb_out_t              awaited_results [$];
  stim_row_t             directed_rows [DIRECTED_ROWS];

  int unsigned           tx_idle_pct;
  int unsigned           rx_idle_pct;
  int unsigned           mismatches;
  int unsigned           quiet_cycles;

  clamped_histogram_binner_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // bin prediction
  // ---------------------------------------------------------------------------

  // bin an add lands in under the current registers
  function automatic logic [BIN_W-1:0] bin_for_sample(input logic [SAMPLE_W-1:0] s);
    logic [BIN_W-1:0]    top;
    logic [SAMPLE_W-1:0] w;
    logic [SAMPLE_W:0]   idx;
    // top bin cannot point past the store
    if (int'(hist_top) > int'(NUM_BINS) - 1) begin
      top = BIN_W'(NUM_BINS - 1);
    end else begin
      top = BIN_W'(hist_top);
    end
    // a zero width counts as one
    w = (hist_width == '0) ? SAMPLE_W'(1) : hist_width;
    // lower test wins when the bounds are crossed
    if (s < hist_lower) begin
      return '0;
    end
    if (s >= hist_upper) begin
      return top;
    end
    idx = (SAMPLE_W + 1)'((s - hist_lower) / w) + 1'b1;
    if (idx > (SAMPLE_W + 1)'(top)) begin
      return top;
    end
    return idx[BIN_W-1:0];
  endfunction

  // apply one request to the bench bins and return the result it gives
  function automatic chb_out_t apply_histogram_request(input chb_in_t req);
    chb_out_t         res;
    logic [BIN_W-1:0] b;
    if (req.cmd == CMD_ADD) begin
      b = bin_for_sample(req.sample);
      // counters saturate at all ones
      if (bin_tally[b] != COUNT_MAX) begin
        bin_tally[b] = bin_tally[b] + 1'b1;
      end
      res.bin_number = b;
      res.bin_count  = bin_tally[b];
    end else begin
      // read, read-clear and the spare code (a plain read)
      res.bin_number = req.bin_select;
      if (int'(req.bin_select) >= int'(NUM_BINS)) begin
        res.bin_count = '0;
      end else begin
        res.bin_count = bin_tally[req.bin_select];
        if (req.cmd == CMD_READ_CLEAR) begin
          bin_tally[req.bin_select] = '0;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // hand one request to the block, keeping push high from the last one
  // unless a gap is taken; the prediction is queued on acceptance
  task automatic send_request(input chb_in_t req, input bit typed,
                              input chb_out_t typed_res);
    chb_out_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= req;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    predicted = apply_histogram_request(req);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic stop_requests();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_until_drained();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // single register write; valid drops for a cycle after each one
  task automatic write_reg(input cfg_reg_e idx, input logic [SAMPLE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      CFG_LOWER: hist_lower = data;
      CFG_UPPER: hist_upper = data;
      CFG_WIDTH: hist_width = data;
      CFG_TOP:   hist_top   = data[TOP_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // register set for sub-phase k; the block must be idle
  task automatic program_setting(input int unsigned k);
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] w;
    logic [TOP_W-1:0]    t;
    case (k % 6)
      0: begin  // reset values
        lo = '0; up = SAMPLE_MAX; w = SAMPLE_W'(1); t = '1;
      end
      1: begin  // 6.4 .. 7.4 in steps of 0.1, in hundredths
        lo = SAMPLE_W'(640); up = SAMPLE_W'(740); w = SAMPLE_W'(10); t = TOP_W'(11);
      end
      2: begin  // crossed bounds, widest bin, top bin one
        lo = SAMPLE_MAX; up = '0; w = SAMPLE_MAX; t = TOP_W'(1);
      end
      3: begin  // narrow random window
        lo = SAMPLE_W'($urandom_range(1000));
        up = lo + SAMPLE_W'($urandom_range(2000));
        w  = SAMPLE_W'($urandom_range(100, 1));
        t  = TOP_W'($urandom_range(31));
      end
      4: begin  // zero width and top bin zero
        lo = SAMPLE_W'($urandom); up = SAMPLE_W'($urandom); w = '0; t = '0;
      end
      default: begin  // anything goes
        lo = SAMPLE_W'($urandom_range(20000));
        up = SAMPLE_W'($urandom);
        w  = SAMPLE_W'($urandom_range(3000));
        t  = TOP_W'($urandom);
      end
    endcase
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_UPPER, up);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_TOP, t);
  endtask

  // samples aimed at the bounds and the bin edges under the current registers
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    longint unsigned span;
    longint unsigned edge_pos;
    longint unsigned w;
    longint unsigned s;
    w    = (hist_width == '0) ? 1 : longint'(hist_width);
    span = w * (longint'(hist_top) + 2);
    case ($urandom_range(9))
      0: s = $urandom;
      1: s = (hist_lower == '0) ? 0 : $urandom_range(int'(hist_lower) - 1);
      2: s = $urandom_range(int'(SAMPLE_MAX), int'(hist_upper));
      3: s = hist_lower;
      4: s = (hist_upper == '0) ? 0 : longint'(hist_upper) - $urandom_range(1);
      5, 6: begin  // either side of a bin edge
        edge_pos = longint'(hist_lower) + w * $urandom_range(int'(hist_top) + 1);
        s = edge_pos - ((edge_pos > 0) ? $urandom_range(1) : 0);
      end
      default: s = longint'(hist_lower) + $urandom_range(32'(span));
    endcase
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    return SAMPLE_W'(s);
  endfunction

  function automatic chb_in_t random_request();
    chb_in_t     req;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      req.cmd = CMD_ADD;
    end else if (r < 80) begin
      req.cmd = CMD_READ;
    end else if (r < 90) begin
      req.cmd = CMD_READ_CLEAR;
    end else begin
      req.cmd = CMD_ALIAS;
    end
    req.sample     = pick_sample();
    req.bin_select = BIN_W'($urandom);
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stalls at the current rate
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // in-order check of every result taken
  always @(posedge clk_i) begin
    chb_out_t want;
    if (rst_ni && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $error("result bin %0d count %0d with no request outstanding",
               out_item_o.bin_number, out_item_o.bin_count);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_item_o.bin_number !== want.bin_number) begin
          $error("bin_number: expected %0d, got %0d",
                 want.bin_number, out_item_o.bin_number);
          mismatches++;
        end
        if (out_item_o.bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, got %0d",
                 want.bin_count, out_item_o.bin_count);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no request, result or write taken
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL clamped_histogram_binner_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    chb_in_t  req;
    chb_out_t res;

    mismatches   = 0;
    quiet_cycles = 0;
    tx_idle_pct  = 27;
    rx_idle_pct  = 73;
    hist_lower   = LOWER_RST;
    hist_upper   = UPPER_RST;
    hist_width   = WIDTH_RST;
    hist_top     = TOP_RST;
    foreach (bin_tally[i]) bin_tally[i] = '0;

    // reset defaults: bin = sample + 1, clamped to 31
    directed_rows = '{
      '{ROW_REQ, CMD_READ,       20'd0,       5'd0,  CFG_LOWER, 1'b1, 5'd0,  32'd0},
      '{ROW_REQ, CMD_READ,       20'd0,       5'd31, CFG_LOWER, 1'b1, 5'd31, 32'd0},
      '{ROW_REQ, CMD_READ_CLEAR, 20'd0,       5'd17, CFG_LOWER, 1'b1, 5'd17, 32'd0},
      '{ROW_REQ, CMD_ALIAS,      20'd0,       5'd5,  CFG_LOWER, 1'b1, 5'd5,  32'd0},
      '{ROW_REQ, CMD_ADD,        20'd0,       5'd0,  CFG_LOWER, 1'b1, 5'd1,  32'd1},
      '{ROW_REQ, CMD_ADD,        20'd29,      5'd0,  CFG_LOWER, 1'b1, 5'd30, 32'd1},
      // interior bin 32 clamps to the top
      '{ROW_REQ, CMD_ADD,        20'd31,      5'd0,  CFG_LOWER, 1'b1, 5'd31, 32'd1},
      // at the upper bound
      '{ROW_REQ, CMD_ADD,        20'hFFFFF,   5'd0,  CFG_LOWER, 1'b1, 5'd31, 32'd2},
      '{ROW_REQ, CMD_ADD,        20'd0,       5'd0,  CFG_LOWER, 1'b1, 5'd1,  32'd2},
      '{ROW_REQ, CMD_READ,       20'hFFFFF,   5'd1,  CFG_LOWER, 1'b1, 5'd1,  32'd2},
      '{ROW_REQ, CMD_READ_CLEAR, 20'd0,       5'd1,  CFG_LOWER, 1'b1, 5'd1,  32'd2},
      '{ROW_REQ, CMD_READ,       20'd0,       5'd1,  CFG_LOWER, 1'b1, 5'd1,  32'd0},
      '{ROW_REQ, CMD_ALIAS,      20'd0,       5'd31, CFG_LOWER, 1'b1, 5'd31, 32'd2},
      '{ROW_REQ, CMD_READ_CLEAR, 20'd0,       5'd31, CFG_LOWER, 1'b1, 5'd31, 32'd2},
      // top bin zero sends everything to bin 0
      '{ROW_CFG, CMD_ADD,        20'd0,       5'd0,  CFG_TOP,   1'b0, 5'd0,  32'd0},
      '{ROW_REQ, CMD_ADD,        20'hABCDE,   5'd0,  CFG_LOWER, 1'b1, 5'd0,  32'd1},
      // upper bound below lower bound
      '{ROW_CFG, CMD_ADD,        20'd31,      5'd0,  CFG_TOP,   1'b0, 5'd0,  32'd0},
      '{ROW_CFG, CMD_ADD,        20'd100,     5'd0,  CFG_LOWER, 1'b0, 5'd0,  32'd0},
      '{ROW_CFG, CMD_ADD,        20'd50,      5'd0,  CFG_UPPER, 1'b0, 5'd0,  32'd0},
      '{ROW_REQ, CMD_ADD,        20'd99,      5'd0,  CFG_LOWER, 1'b1, 5'd0,  32'd2},
      '{ROW_REQ, CMD_ADD,        20'd100,     5'd0,  CFG_LOWER, 1'b1, 5'd31, 32'd1},
      // zero bin width
      '{ROW_CFG, CMD_ADD,        20'd0,       5'd0,  CFG_WIDTH, 1'b0, 5'd0,  32'd0},
      '{ROW_CFG, CMD_ADD,        20'd0,       5'd0,  CFG_LOWER, 1'b0, 5'd0,  32'd0},
      '{ROW_REQ, CMD_ADD,        20'd7,       5'd0,  CFG_LOWER, 1'b0, 5'd0,  32'd0},
      '{ROW_REQ, CMD_ADD,        20'h5A5A5,   5'd0,  CFG_LOWER, 1'b0, 5'd0,  32'd0}
    };

    // reset held at the start, released once
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; register writes only with nothing in flight
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        stop_requests();
        wait_until_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        req.cmd        = directed_rows[i].cmd;
        req.sample     = directed_rows[i].value;
        req.bin_select = directed_rows[i].sel;
        res.bin_number = directed_rows[i].exp_bin;
        res.bin_count  = directed_rows[i].exp_count;
        send_request(req, directed_rows[i].typed, res);
      end
    end

    // random part: slow receiver, then slow sender, then full rate
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 27; rx_idle_pct = 73; end
        1: begin tx_idle_pct = 73; rx_idle_pct = 27; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int unsigned sub = 0; sub < SUB_PHASES; sub++) begin
        stop_requests();
        wait_until_drained();
        program_setting(phase * SUB_PHASES + sub);
        for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
          // sender holds off mid-stream until the block has emptied
          if (n == PHASE_ITEMS / 2) begin
            stop_requests();
            wait_until_drained();
          end
          send_request(random_request(), 1'b0, '0);
        end
      end
    end

    stop_requests();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS clamped_histogram_binner_top");
    end else begin
      $display("FAIL clamped_histogram_binner_top");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/chb_pkg.sv
hdl/chb_front.sv
hdl/chb_cmd_queue.sv
hdl/chb_back.sv
hdl/clamped_histogram_binner_top.sv
hdl/chb_checker.sv
sim/tb_clamped_histogram_binner_top.sv
